// ----- hdl/kdpc_pkg.sv -----
// Shared types, constants and codes for the key debounce press classifier.
package kdpc_pkg;

  localparam int KEY_COUNT_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE        = 2'd0,
    ST_PRESS_DEB   = 2'd1,
    ST_PRESSED     = 2'd2,
    ST_RELEASE_DEB = 2'd3
  } press_state_t;

  typedef struct packed {
    logic [2:0]  key_index;
    logic [31:0] time_now;
    logic        pin_level;
    logic        edge_seen;
    logic        flag_ack;
  } in_item_t;

  typedef struct packed {
    logic [2:0]   key_number;
    press_state_t press_state;
    logic         short_flag;
    logic         long_flag;
  } out_item_t;

  // Per-key word layout: {start_time, state, pending, short, long}
  localparam int FLAG_BITS = 5;

endpackage

// ----- hdl/key_debounce_press_classifier.sv -----
// Top level: key press classifier with per-key state RAM and APB registers.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_ready   in_item  (in_item_t)
//   out       source     out_valid / out_ready out_item (out_item_t)
//   cfg       APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One transaction per cycle sustained while the output register is free or
// draining. The state RAM read and stage 1 load at the accepting edge; the
// update, write back and output register load happen when stage 1 advances.
// A step on the same key as the one just written picks up the RAM bypass.
// rst is synchronous; the per-key valid bits clear at once, so there is no
// clearing pass and the block takes transactions right after reset.
// A stalled output register holds the update stage, which holds in_ready low.
module key_debounce_press_classifier import kdpc_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int KEY_W  = (IDX_W > 3) ? IDX_W : 3;
  localparam int WORD_W = TIME_BITS + FLAG_BITS;

  // configuration registers
  logic [15:0] debounce_time;
  logic [15:0] long_press_time;
  reg_index_t  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_DEBOUNCE:   debounce_time   <= pwdata[15:0];
        REG_LONG_PRESS: long_press_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE:   prdata = APB_DATA_W'(debounce_time);
      REG_LONG_PRESS: prdata = APB_DATA_W'(long_press_time);
      default:        prdata = '0;
    endcase
  end

  // stage 0: accept and issue RAM read
  logic [KEY_W-1:0] in_key_ext;
  logic             in_in_range;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  assign in_key_ext  = KEY_W'(in_item.key_index);
  assign in_in_range = int'(in_item.key_index) < KEY_COUNT;
  assign rd_addr     = in_in_range ? in_key_ext[IDX_W-1:0] : '0;
  assign rd_en       = in_valid && in_ready;

  // stage 1: update and write back
  logic             s1_valid;
  in_item_t         s1_item;
  logic             s1_in_range;
  logic             s1_adv;
  logic [KEY_W-1:0] s1_key_ext;
  logic [WORD_W-1:0] word_cur;
  logic [WORD_W-1:0] word_next;
  press_state_t     step_state;
  logic             step_short;
  logic             step_long;

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_adv;
  assign s1_key_ext = KEY_W'(s1_item.key_index);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_item     <= in_item;
      s1_in_range <= in_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  kdpc_key_ram #(
    .DEPTH  (KEY_COUNT),
    .ADDR_W (IDX_W),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (word_cur),
    .wr_en   (s1_adv && s1_in_range),
    .wr_addr (s1_key_ext[IDX_W-1:0]),
    .wr_data (word_next)
  );

  kdpc_step #(
    .TIME_BITS (TIME_BITS),
    .WORD_W    (WORD_W)
  ) u_step (
    .word_cur        (word_cur),
    .now             (TIME_BITS'(s1_item.time_now)),
    .pin_high        (s1_item.pin_level),
    .edge_seen       (s1_item.edge_seen),
    .flag_ack        (s1_item.flag_ack),
    .debounce_time   (debounce_time),
    .long_press_time (long_press_time),
    .word_next       (word_next),
    .state_out       (step_state),
    .short_out       (step_short),
    .long_out        (step_long)
  );

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item.key_number <= s1_item.key_index;
      if (s1_in_range) begin
        out_item.press_state <= step_state;
        out_item.short_flag  <= step_short;
        out_item.long_flag   <= step_long;
      end else begin
        out_item.press_state <= ST_IDLE;
        out_item.short_flag  <= 1'b0;
        out_item.long_flag   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // an accepted transaction always reaches the update stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted transaction did not reach update stage");

  // a stalled update stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled update stage lost its transaction");

  // keys outside the array report idle with no flags
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(int'(out_item.key_number) < KEY_COUNT)) |->
      (out_item.press_state == ST_IDLE && !out_item.short_flag && !out_item.long_flag))
    else $error("out-of-range key produced state");

  // the update stage only advances into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("pending result overwritten");

endmodule

// ----- hdl/kdpc_key_ram.sv -----
// Per-key state memory with reset valid bits and write-to-read forwarding.
module kdpc_key_ram import kdpc_pkg::*; #(
  parameter int DEPTH  = KEY_COUNT_DEF,
  parameter int ADDR_W = 3,
  parameter int WORD_W = TIME_BITS_DEF + FLAG_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;

  logic [WORD_W-1:0] rd_q;
  logic              rd_written;
  logic [ADDR_W-1:0] rd_addr_q;

  // last write, kept to cover a read issued in the same cycle as that write
  logic              byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  logic [WORD_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_addr_q  <= rd_addr;
    end
    if (wr_en) begin
      byp_addr <= wr_addr;
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      byp_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
        byp_valid        <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  always_comb begin
    if (byp_valid && (byp_addr == rd_addr_q)) begin
      rd_data = byp_data;
    end else if (rd_written) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ----- hdl/kdpc_step.sv -----
// One transition of a key's press machine: ack, edge latch, then state move.
module kdpc_step import kdpc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int WORD_W    = TIME_BITS_DEF + FLAG_BITS
) (
  input  logic [WORD_W-1:0]    word_cur,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 pin_high,
  input  logic                 edge_seen,
  input  logic                 flag_ack,
  input  logic [15:0]          debounce_time,
  input  logic [15:0]          long_press_time,
  output logic [WORD_W-1:0]    word_next,
  output press_state_t         state_out,
  output logic                 short_out,
  output logic                 long_out
);

  localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [TIME_BITS-1:0] start_cur;
  logic [TIME_BITS-1:0] start_next;
  logic [TIME_BITS-1:0] elapsed;
  press_state_t         state_cur;
  press_state_t         state_next;
  logic                 pending_next;
  logic                 short_next;
  logic                 long_next;
  logic                 deb_done;
  logic                 hold_done;

  assign start_cur = word_cur[WORD_W-1:FLAG_BITS];
  assign state_cur = press_state_t'(word_cur[4:3]);
  assign elapsed   = now - start_cur;  // wraps modulo 2^TIME_BITS
  assign deb_done  = CMP_W'(elapsed) >= CMP_W'(debounce_time);
  assign hold_done = CMP_W'(elapsed) >= CMP_W'(long_press_time);

  always_comb begin
    start_next   = start_cur;
    state_next   = state_cur;
    pending_next = word_cur[2] | edge_seen;
    short_next   = word_cur[1] & ~flag_ack;
    long_next    = word_cur[0] & ~flag_ack;
    case (state_cur)
      ST_IDLE: begin
        if (pending_next) begin
          pending_next = 1'b0;
          state_next   = ST_PRESS_DEB;
          start_next   = now;
        end
      end
      ST_PRESS_DEB: begin
        if (deb_done) begin
          if (!pin_high) begin
            state_next = ST_PRESSED;
            start_next = now;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (hold_done) begin
          long_next = 1'b1;
        end
        if (pin_high) begin
          state_next = ST_RELEASE_DEB;
          start_next = now;
        end
      end
      ST_RELEASE_DEB: begin
        if (deb_done) begin
          if (pin_high) begin
            if (!long_next) begin
              short_next = 1'b1;
            end
            state_next = ST_IDLE;
          end else begin
            state_next = ST_PRESSED;  // start time kept on a bounce back
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign word_next = {start_next, state_next, pending_next, short_next, long_next};
  assign state_out = state_next;
  assign short_out = short_next;
  assign long_out  = long_next;

endmodule
